@@ hdl/iem_pkg.sv @@
// ----------------------------------------------------------------------------
// ICMP echo reply matcher package
// Shared types, header offsets and constants for the echo reply filter.
// ----------------------------------------------------------------------------
package iem_pkg;

    localparam int DEFAULT_MAX_FRAME_BYTES = 2048;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [7:0]  IP_PROTO_ICMP  = 8'd1;
    localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;
    localparam logic [7:0]  ICMP_CODE_ZERO  = 8'd0;
    localparam logic [5:0]  MIN_IP_HEADER  = 6'd20;
    localparam logic [31:0] LOCAL_IP_RESET = 32'h0A00_020F;

    localparam int ETH_HEADER  = 14;
    localparam int ICMP_HEADER = 8;

    localparam int POS_ETYPE_HI = 12;
    localparam int POS_ETYPE_LO = 13;
    localparam int POS_VER_IHL  = 14;
    localparam int POS_PROTO    = 23;
    localparam int POS_SRC_IP   = 26;
    localparam int POS_DST_IP   = 30;
    localparam int POS_L4_MIN   = 34;

    localparam logic [2:0] ICMP_OFF_TYPE   = 3'd0;
    localparam logic [2:0] ICMP_OFF_CODE   = 3'd1;
    localparam logic [2:0] ICMP_OFF_ID_HI  = 3'd4;
    localparam logic [2:0] ICMP_OFF_ID_LO  = 3'd5;
    localparam logic [2:0] ICMP_OFF_SEQ_HI = 3'd6;
    localparam logic [2:0] ICMP_OFF_SEQ_LO = 3'd7;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_EXPECTED_SOURCE_IP = 2'd0,
        CFG_LOCAL_IP           = 2'd1,
        CFG_ECHO_IDENTIFIER    = 2'd2,
        CFG_ECHO_SEQUENCE      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] expected_source_ip;
        logic [31:0] local_ip;
        logic [15:0] echo_identifier;
        logic [15:0] echo_sequence;
    } t_cfg;

    function automatic logic [7:0] byte_of32(input logic [31:0] word, input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = word[31:24];
            2'd1: b = word[23:16];
            2'd2: b = word[15:8];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

endpackage

@@ hdl/icmp_echo_reply_matcher.sv @@
// ----------------------------------------------------------------------------
// ICMP echo reply matcher
// Filters received Ethernet frames one byte per word and reports, on the
// last word of each frame, whether it is the expected ICMP echo reply.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s       | in        | tvalid/tready      | tdata[7:0] frame byte, tlast last byte
//  m       | out       | tvalid/tready      | tdata[0] reply matched, [7:1] zero
//  cfg     | in        | we                 | addr register index, wdata value
//
//  One word per cycle unless a last word waits for the result slot; a verdict
//  leaves through the input register, then the result register.
//  Synchronous active-low reset clears the frame state and both valid flags.
//  A stalled verdict holds the result register; non-last words keep flowing
//  until a second last word needs the result slot.
module icmp_echo_reply_matcher
    import iem_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] frame_byte
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,   // [0] reply_matched, [7:1] zero
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    logic       r_out_match;

    logic       out_free;
    logic       advance;
    logic       match;

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_match};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_source_ip <= '0;
            r_cfg.local_ip           <= LOCAL_IP_RESET;
            r_cfg.echo_identifier    <= '0;
            r_cfg.echo_sequence      <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_EXPECTED_SOURCE_IP: r_cfg.expected_source_ip <= i_cfg_wdata;
                CFG_LOCAL_IP:           r_cfg.local_ip           <= i_cfg_wdata;
                CFG_ECHO_IDENTIFIER:    r_cfg.echo_identifier    <= i_cfg_wdata[15:0];
                CFG_ECHO_SEQUENCE:      r_cfg.echo_sequence      <= i_cfg_wdata[15:0];
                default:                r_cfg                    <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    iem_frame_check #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_match (match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_match <= match;
        end
    end

endmodule

@@ hdl/iem_frame_check.sv @@
// ----------------------------------------------------------------------------
// ICMP echo reply frame checker
// Tracks the byte position, IP header length and running match flag of one
// frame and gives the verdict for the word being stepped in.
// ----------------------------------------------------------------------------
module iem_frame_check
    import iem_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_match
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES);
    localparam int EXT_W = POS_W + 1;

    logic [POS_W-1:0] r_pos;
    logic [5:0]       r_ihb;
    logic             r_ok;

    logic [5:0]       n_ihb;
    logic             n_ok;
    logic             byte_good;
    logic [EXT_W-1:0] pos_ext;
    logic [EXT_W-1:0] l4_start;
    logic [EXT_W-1:0] l4_off;
    logic [EXT_W-1:0] min_len;
    logic [1:0]       ip_idx;

    assign pos_ext  = {1'b0, r_pos};
    assign l4_start = EXT_W'(ETH_HEADER) + EXT_W'(r_ihb);
    assign l4_off   = pos_ext - l4_start;
    assign ip_idx   = r_pos[1:0] - 2'd2;
    assign n_ihb    = (r_pos == POS_W'(POS_VER_IHL)) ? {i_byte[3:0], 2'b00} : r_ihb;
    assign min_len  = EXT_W'(ETH_HEADER + ICMP_HEADER - 1) + EXT_W'(n_ihb);

    always_comb begin
        byte_good = 1'b1;
        if (r_pos == POS_W'(POS_ETYPE_HI)) begin
            byte_good = (i_byte == ETHERTYPE_IPV4[15:8]);
        end else if (r_pos == POS_W'(POS_ETYPE_LO)) begin
            byte_good = (i_byte == ETHERTYPE_IPV4[7:0]);
        end else if (r_pos == POS_W'(POS_VER_IHL)) begin
            byte_good = (i_byte[7:4] == IP_VERSION_4) && (n_ihb >= MIN_IP_HEADER);
        end else if (r_pos == POS_W'(POS_PROTO)) begin
            byte_good = (i_byte == IP_PROTO_ICMP);
        end else if (r_pos >= POS_W'(POS_SRC_IP) && r_pos < POS_W'(POS_DST_IP)) begin
            byte_good = (i_byte == byte_of32(i_cfg.expected_source_ip, ip_idx));
        end else if (r_pos >= POS_W'(POS_DST_IP) && r_pos < POS_W'(POS_L4_MIN)) begin
            byte_good = (i_byte == byte_of32(i_cfg.local_ip, ip_idx));
        end else if (r_pos >= POS_W'(POS_L4_MIN) && pos_ext >= l4_start
                     && l4_off < EXT_W'(ICMP_HEADER)) begin
            case (l4_off[2:0])
                ICMP_OFF_TYPE:   byte_good = (i_byte == ICMP_ECHO_REPLY);
                ICMP_OFF_CODE:   byte_good = (i_byte == ICMP_CODE_ZERO);
                ICMP_OFF_ID_HI:  byte_good = (i_byte == i_cfg.echo_identifier[15:8]);
                ICMP_OFF_ID_LO:  byte_good = (i_byte == i_cfg.echo_identifier[7:0]);
                ICMP_OFF_SEQ_HI: byte_good = (i_byte == i_cfg.echo_sequence[15:8]);
                ICMP_OFF_SEQ_LO: byte_good = (i_byte == i_cfg.echo_sequence[7:0]);
                default:         byte_good = 1'b1;
            endcase
        end
    end

    assign n_ok    = r_ok & byte_good;
    assign o_match = n_ok && (n_ihb >= MIN_IP_HEADER) && (pos_ext >= min_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ihb <= '0;
            r_ok  <= 1'b1;
        end else if (i_step) begin
            if (i_last) begin
                r_pos <= '0;
                r_ihb <= '0;
                r_ok  <= 1'b1;
            end else begin
                if (r_pos < POS_W'(MAX_FRAME_BYTES - 1)) begin
                    r_pos <= r_pos + POS_W'(1);
                end
                r_ihb <= n_ihb;
                r_ok  <= n_ok;
            end
        end
    end

endmodule
